// File: hw/rtl/rtcc_pkg.sv
// Shared types, codes and calendar helpers for the real-time clock calendar.
// Used by the set checker, the month step unit and the top level.
`default_nettype none

package rtcc_pkg;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } date_t;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_ADD  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SET_ERR = 2'd1;
  localparam logic [1:0] STATUS_OVER    = 2'd2;

  localparam logic [5:0] SEC_LAST    = 6'd59;
  localparam logic [5:0] MIN_LAST    = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [4:0] DAY_FIRST   = 5'd1;
  localparam logic [4:0] DAY_LAST    = 5'd31;
  localparam logic [4:0] DAY_FEB_MAX = 5'd28;
  localparam logic [4:0] LEAP_DROP   = 5'd28;
  localparam logic [4:0] COMMON_DROP = 5'd27;
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [6:0] YEAR_LAST   = 7'd99;

  localparam logic [5:0] RESET_SECOND = 6'd0;
  localparam logic [5:0] RESET_MINUTE = 6'd0;
  localparam logic [4:0] RESET_HOUR   = 5'd0;
  localparam logic [4:0] RESET_DAY    = 5'd1;
  localparam logic [3:0] RESET_MONTH  = 4'd1;
  localparam logic [6:0] RESET_YEAR   = 7'd22;

  function automatic logic is_short_month(input logic [3:0] m);
    return (m == 4'd4) || (m == 4'd6) || (m == 4'd9) || (m == 4'd11);
  endfunction

  function automatic logic is_leap(input logic [6:0] y);
    return y[1:0] == 2'b00;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else if (is_short_month(m)) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtcc_set_check.sv
// Range, month-length and leap checks on a requested date and time.
// Depends on rtcc_pkg.
`default_nettype none

module rtcc_set_check (
  input  wire logic [6:0] day,
  input  wire logic [6:0] month,
  input  wire logic [6:0] year,
  input  wire logic [6:0] hour,
  input  wire logic [6:0] minute,
  input  wire logic [6:0] second,
  output logic            set_ok
);
  import rtcc_pkg::*;

  logic       range_ok;
  logic       feb_ok;
  logic       short_ok;
  logic [3:0] m4;
  logic [4:0] d5;

  assign m4 = month[3:0];
  assign d5 = day[4:0];

  always_comb begin
    range_ok = (year <= 7'(YEAR_LAST)) && (month != 7'd0) && (month <= 7'(MONTH_LAST))
            && (day != 7'd0) && (day <= 7'(DAY_LAST))
            && (hour <= 7'(HOUR_LAST)) && (minute <= 7'(MIN_LAST))
            && (second <= 7'(SEC_LAST));
    feb_ok   = !((m4 == MONTH_FEB) && (d5 > DAY_FEB_MAX))
            || (is_leap(year) && (d5 == DAY_FEB_MAX + 5'd1));
    short_ok = !((d5 == DAY_LAST) && is_short_month(m4));
    set_ok   = range_ok && feb_ok && short_ok;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtcc_month_step.sv
// One-month step of the future-date search, with day overflow into the next month and year carry.
// Depends on rtcc_pkg.
`default_nettype none

module rtcc_month_step (
  input  rtcc_pkg::date_t cur,
  output rtcc_pkg::date_t nxt,
  output logic            over
);
  import rtcc_pkg::*;

  logic       wrap;
  logic [3:0] m1;
  logic [6:0] y1;

  always_comb begin
    wrap = cur.month >= MONTH_LAST;
    m1   = wrap ? MONTH_FIRST : cur.month + 4'd1;
    y1   = wrap ? cur.year + 7'd1 : cur.year;
    over = wrap && (cur.year >= YEAR_LAST);
    nxt.day   = cur.day;
    nxt.month = m1;
    nxt.year  = y1;
    if (is_short_month(m1)) begin
      if (cur.day == DAY_LAST) begin
        nxt.day   = DAY_FIRST;
        nxt.month = m1 + 4'd1;
      end
    end else if ((m1 == MONTH_FEB) && (cur.day > DAY_FEB_MAX)) begin
      nxt.day   = cur.day - (is_leap(y1) ? LEAP_DROP : COMMON_DROP);
      nxt.month = m1 + 4'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtc_calendar_with_month_add.sv
// Real-time clock calendar with tick, checked set and month-add query.
// Tick and set pass through their own state and then S_DONE to result valid; an unused mode goes to S_DONE.
// Query: one month step a cycle in S_ADD, stopping early on year overflow.
// One item at a time; a new beat is taken while the previous result waits.
// Reset: 00:00:00 01/01/22, no result pending, ready once rst is released.
// Depends on rtcc_pkg, rtcc_set_check and rtcc_month_step.
`default_nettype none

module rtc_calendar_with_month_add (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [6:0] set_day,
  input  wire logic [6:0] set_month,
  input  wire logic [6:0] set_year,
  input  wire logic [6:0] set_hour,
  input  wire logic [6:0] set_minute,
  input  wire logic [6:0] set_second,
  input  wire logic [6:0] months_to_add,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic [4:0]      hour_now,
  output logic [5:0]      minute_now,
  output logic [5:0]      second_now,
  output logic [4:0]      day_now,
  output logic [3:0]      month_now,
  output logic [6:0]      year_now,
  output logic [4:0]      future_day,
  output logic [3:0]      future_month,
  output logic [6:0]      future_year
);
  import rtcc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_SET, S_ADD, S_DONE} state_t;

  state_t     state;
  logic [5:0] second_count;
  logic [5:0] minute_count;
  logic [4:0] hour_count;
  logic [4:0] day_count;
  logic [3:0] month_count;
  logic [6:0] year_count;

  logic [6:0] new_day;
  logic [6:0] new_month;
  logic [6:0] new_year;
  logic [6:0] new_hour;
  logic [6:0] new_minute;
  logic [6:0] new_second;
  logic [6:0] remaining;
  date_t      work;
  date_t      fut;
  logic [1:0] res_status;

  logic       set_ok;
  date_t      step_date;
  logic       step_over;

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic       year_wrap;
  logic [5:0] second_next;
  logic [5:0] minute_next;
  logic [4:0] hour_next;
  logic [4:0] day_next;
  logic [3:0] month_next;
  logic [6:0] year_next;

  logic       in_fire;
  logic       out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  rtcc_set_check u_check (
    .day    (new_day),
    .month  (new_month),
    .year   (new_year),
    .hour   (new_hour),
    .minute (new_minute),
    .second (new_second),
    .set_ok (set_ok)
  );

  rtcc_month_step u_step (
    .cur  (work),
    .nxt  (step_date),
    .over (step_over)
  );

  always_comb begin
    sec_wrap    = second_count == SEC_LAST;
    min_wrap    = sec_wrap && (minute_count == MIN_LAST);
    hour_wrap   = min_wrap && (hour_count == HOUR_LAST);
    day_wrap    = hour_wrap && (day_count >= month_length(month_count, year_count));
    month_wrap  = day_wrap && (month_count >= MONTH_LAST);
    year_wrap   = month_wrap && (year_count >= YEAR_LAST);
    second_next = sec_wrap ? 6'd0 : second_count + 6'd1;
    minute_next = sec_wrap ? (min_wrap ? 6'd0 : minute_count + 6'd1) : minute_count;
    hour_next   = min_wrap ? (hour_wrap ? 5'd0 : hour_count + 5'd1) : hour_count;
    day_next    = hour_wrap ? (day_wrap ? DAY_FIRST : day_count + 5'd1) : day_count;
    month_next  = day_wrap ? (month_wrap ? MONTH_FIRST : month_count + 4'd1) : month_count;
    year_next   = month_wrap ? (year_wrap ? 7'd0 : year_count + 7'd1) : year_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      second_count <= RESET_SECOND;
      minute_count <= RESET_MINUTE;
      hour_count   <= RESET_HOUR;
      day_count    <= RESET_DAY;
      month_count  <= RESET_MONTH;
      year_count   <= RESET_YEAR;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            new_day    <= set_day;
            new_month  <= set_month;
            new_year   <= set_year;
            new_hour   <= set_hour;
            new_minute <= set_minute;
            new_second <= set_second;
            remaining  <= months_to_add;
            work       <= '{day: day_count, month: month_count, year: year_count};
            fut        <= '0;
            res_status <= STATUS_OK;
            unique case (mode)
              MODE_TICK: state <= S_TICK;
              MODE_SET:  state <= S_SET;
              MODE_ADD:  state <= S_ADD;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_TICK: begin
          second_count <= second_next;
          minute_count <= minute_next;
          hour_count   <= hour_next;
          day_count    <= day_next;
          month_count  <= month_next;
          year_count   <= year_next;
          state        <= S_DONE;
        end
        S_SET: begin
          if (set_ok) begin
            day_count    <= new_day[4:0];
            month_count  <= new_month[3:0];
            year_count   <= new_year;
            hour_count   <= new_hour[4:0];
            minute_count <= new_minute[5:0];
            second_count <= new_second[5:0];
          end else begin
            res_status <= STATUS_SET_ERR;
          end
          state <= S_DONE;
        end
        S_ADD: begin
          if (remaining == 7'd0) begin
            fut   <= work;
            state <= S_DONE;
          end else if (step_over) begin
            res_status <= STATUS_OVER;
            state      <= S_DONE;
          end else begin
            work      <= step_date;
            remaining <= remaining - 7'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            hour_now     <= hour_count;
            minute_now   <= minute_count;
            second_now   <= second_count;
            day_now      <= day_count;
            month_now    <= month_count;
            year_now     <= year_count;
            future_day   <= fut.day;
            future_month <= fut.month;
            future_year  <= fut.year;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (hour_count <= HOUR_LAST) && (minute_count <= MIN_LAST) && (second_count <= SEC_LAST))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (month_count >= MONTH_FIRST) && (month_count <= MONTH_LAST) && (day_count >= DAY_FIRST)
    && (day_count <= month_length(month_count, year_count)) && (year_count <= YEAR_LAST))
    else $error("calendar date out of range");

  a_work_month: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> ((work.month >= MONTH_FIRST) && (work.month <= MONTH_LAST)))
    else $error("month step left the valid month range");

  a_over_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_OVER))
    |-> ((future_day == 5'd0) && (future_month == 4'd0) && (future_year == 7'd0)))
    else $error("future date not cleared on year overflow");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("ready again right after an accepted beat");

endmodule

`default_nettype wire
